[design/anxb_pkg.sv]
`default_nettype none

package anxb_pkg;

  // Frame length limit and the width of every byte count and offset.
  localparam int unsigned MAX_FRAME_BYTES = 4194304;
  localparam int unsigned LEN_W           = 23;
  localparam int unsigned MIN_FRAME_BYTES = 4;

  typedef logic [LEN_W-1:0] len_t;

  localparam len_t MAX_LEN = len_t'(MAX_FRAME_BYTES);
  localparam len_t MIN_LEN = len_t'(MIN_FRAME_BYTES);

  // Start-code bytes.
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // NAL unit types of interest.
  localparam logic [5:0] NAL_SPS_AVC  = 6'd7;
  localparam logic [5:0] NAL_AUD_AVC  = 6'd9;
  localparam logic [5:0] NAL_VPS_HEVC = 6'd32;
  localparam logic [5:0] NAL_AUD_HEVC = 6'd35;

  // Codec selection held in the configuration register.
  typedef enum logic [1:0] {
    CODEC_H264  = 2'd0,
    CODEC_HEVC  = 2'd1,
    CODEC_AV1   = 2'd2,
    CODEC_OTHER = 2'd3
  } codec_t;

  // Parser progress through one frame.
  typedef enum logic [2:0] {
    PH_HDR0,   // looking for the start code at offset zero
    PH_HDR1,   // looking for the start code after a delimiter
    PH_SCAN,   // counting start codes inside the parameter sets
    PH_FOUND,  // end of the config region located
    PH_NONE    // frame carries no config region
  } phase_t;

  // Per-byte view shared by both parsers.
  typedef struct packed {
    logic       proc;       // byte is stored and parsed this cycle
    logic       new_frame;  // byte is the first of a frame
    len_t       idx;        // offset of the byte in the frame
    len_t       len;        // frame length including this byte
    logic [7:0] cur;        // the byte itself
    logic [7:0] w1;         // byte at idx-1
    logic [7:0] w2;         // byte at idx-2
    logic [7:0] w3;         // byte at idx-3
    logic [7:0] w4;         // byte at idx-4
  } byte_info_t;

  // Split decision of one parser.
  typedef struct packed {
    logic cfg_found;
    len_t cfg_off;
    len_t cfg_len;
    len_t pay_off;
    len_t pay_len;
  } split_t;

  // Result transaction, frame_sent in the lowest bit.
  typedef struct packed {
    logic pad;
    logic av1_pulse;
    len_t pay_len;
    len_t pay_off;
    len_t cfg_len;
    len_t cfg_off;
    logic cfg_found;
    logic frame_sent;
  } result_t;

  // NAL type from the first header byte.
  function automatic logic [5:0] nal_type(input logic [7:0] b, input logic hevc);
    logic [5:0] t;
    t = hevc ? b[6:1] : {1'b0, b[4:0]};
    return t;
  endfunction

endpackage

`default_nettype wire

[design/anxb_byte_track.sv]
`default_nettype none

module anxb_byte_track import anxb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       first_of_frame,
  input  logic       last_of_frame,
  output byte_info_t info
);

  len_t       count_r, count_nxt;
  len_t       cur_count;
  logic [7:0] w1_r, w2_r, w3_r, w4_r;
  logic       proc;

  // A first mark restarts the frame; bytes past the limit are ignored.
  always_comb begin
    cur_count = first_of_frame ? '0 : count_r;
    proc      = step && (cur_count < MAX_LEN);
    info.proc      = proc;
    info.new_frame = (cur_count == '0);
    info.idx       = cur_count;
    info.len       = (cur_count < MAX_LEN) ? cur_count + len_t'(1) : cur_count;
    info.cur       = data_byte;
    info.w1        = w1_r;
    info.w2        = w2_r;
    info.w3        = w3_r;
    info.w4        = w4_r;
    count_nxt      = last_of_frame ? '0 : info.len;
  end

  // Byte counter for the current frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step) begin
      count_r <= count_nxt;
    end
  end

  // Four-byte history window.
  always_ff @(posedge clk) begin
    if (proc) begin
      w4_r <= w3_r;
      w3_r <= w2_r;
      w2_r <= w1_r;
      w1_r <= data_byte;
    end
  end

endmodule

`default_nettype wire

[design/anxb_parser.sv]
`default_nettype none

module anxb_parser import anxb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  byte_info_t info,
  input  logic       hevc,
  output split_t     split
);

  phase_t     phase_r, phase_nxt, phase_c;
  logic       aud_r, aud_nxt, aud_c;
  logic       p4_r, p4_nxt;
  logic [2:0] base_r, base_nxt;
  logic [1:0] found_r, found_nxt;
  len_t       skip_at_r, skip_at_nxt;
  len_t       split_r, split_nxt;

  logic [2:0] extra;
  logic [1:0] wanted;
  logic [5:0] nal_aud, nal_ps, typ;
  logic [2:0] hdr_pos;
  len_t       pos3, pos4;
  logic       hit3, hit4, hdr_hit, sc3, sc4, scan_hit;
  logic [3:0] thr;
  logic       skip_ok, cfg_ok;
  len_t       pbase;

  // Codec-dependent constants.
  assign extra   = hevc ? 3'd3 : 3'd2;
  assign wanted  = hevc ? 2'd3 : 2'd2;
  assign nal_aud = hevc ? NAL_AUD_HEVC : NAL_AUD_AVC;
  assign nal_ps  = hevc ? NAL_VPS_HEVC : NAL_SPS_AVC;
  assign typ     = nal_type(info.cur, hevc);

  // A new frame starts from the header search with no delimiter seen.
  assign phase_c = info.new_frame ? PH_HDR0 : phase_r;
  assign aud_c   = info.new_frame ? 1'b0 : aud_r;

  // Header start code at a fixed offset; the current byte is then its NAL type.
  assign hdr_pos = (phase_c == PH_HDR1) ? base_r : 3'd0;
  assign pos3    = len_t'(hdr_pos) + len_t'(3);
  assign pos4    = len_t'(hdr_pos) + len_t'(4);
  assign hit3    = (info.idx == pos3) && (info.w3 == SC_ZERO) && (info.w2 == SC_ZERO)
                   && (info.w1 == SC_ONE);
  assign hit4    = (info.idx == pos4) && (info.w4 == SC_ZERO) && (info.w3 == SC_ZERO)
                   && (info.w2 == SC_ZERO) && (info.w1 == SC_ONE);
  assign hdr_hit = hit3 || hit4;

  // Scan window: start code beginning three bytes back.
  assign sc3      = (info.w3 == SC_ZERO) && (info.w2 == SC_ZERO) && (info.w1 == SC_ONE);
  assign sc4      = (info.w3 == SC_ZERO) && (info.w2 == SC_ZERO) && (info.w1 == SC_ZERO)
                    && (info.cur == SC_ONE);
  assign scan_hit = (info.idx >= skip_at_r) && (sc3 || sc4);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (info.proc) begin
      phase_nxt = phase_c;
      case (phase_c)
        PH_HDR0, PH_HDR1: begin
          if (hdr_hit) begin
            if (typ == nal_ps) begin
              phase_nxt = PH_SCAN;
            end else if ((typ == nal_aud) && (phase_c == PH_HDR0)) begin
              phase_nxt = PH_HDR1;
            end else begin
              phase_nxt = PH_NONE;
            end
          end else if (info.idx == pos4) begin
            phase_nxt = PH_NONE;
          end
        end
        PH_SCAN: begin
          if (scan_hit && (found_r == wanted)) begin
            phase_nxt = PH_FOUND;
          end
        end
        default: begin
          phase_nxt = phase_c;
        end
      endcase
    end
  end

  // Next values of the delimiter, count and position registers.
  always_comb begin
    aud_nxt     = aud_r;
    p4_nxt      = p4_r;
    base_nxt    = base_r;
    found_nxt   = found_r;
    skip_at_nxt = skip_at_r;
    split_nxt   = split_r;
    if (info.proc) begin
      aud_nxt = aud_c;
      case (phase_c)
        PH_HDR0, PH_HDR1: begin
          if (hdr_hit && (typ == nal_ps)) begin
            // The header start code counts as the first one found.
            found_nxt   = 2'd1;
            skip_at_nxt = info.idx + len_t'(3);
          end else if (hdr_hit && (typ == nal_aud) && (phase_c == PH_HDR0)) begin
            aud_nxt  = 1'b1;
            p4_nxt   = hit4;
            base_nxt = (hit4 ? 3'd4 : 3'd3) + extra;
          end
        end
        PH_SCAN: begin
          if (scan_hit) begin
            if (found_r == wanted) begin
              split_nxt = info.idx - len_t'(3);
            end else begin
              found_nxt   = found_r + 2'd1;
              skip_at_nxt = info.idx + (sc4 ? len_t'(4) : len_t'(3));
            end
          end
        end
        default: begin
          found_nxt = found_r;
        end
      endcase
    end
  end

  // Split decision for a frame ending with this byte.
  always_comb begin
    thr     = (p4_nxt ? 4'd8 : 4'd6) + {1'b0, extra};
    skip_ok = aud_nxt && (info.len > len_t'(thr));
    pbase   = skip_ok ? len_t'(base_nxt) : '0;
    cfg_ok  = (phase_nxt == PH_FOUND) && (!aud_nxt || skip_ok);
    split   = '0;
    if (cfg_ok) begin
      split.cfg_found = 1'b1;
      split.cfg_off   = pbase;
      split.cfg_len   = split_nxt - pbase;
      split.pay_off   = split_nxt;
      split.pay_len   = info.len - split_nxt;
    end else begin
      split.pay_off   = pbase;
      split.pay_len   = info.len - pbase;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      aud_r   <= 1'b0;
      found_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      aud_r   <= aud_nxt;
      found_r <= found_nxt;
    end
  end

  // Positions recorded within the frame.
  always_ff @(posedge clk) begin
    p4_r      <= p4_nxt;
    base_r    <= base_nxt;
    skip_at_r <= skip_at_nxt;
    split_r   <= split_nxt;
  end

endmodule

`default_nettype wire

[design/annexb_config_nal_splitter.sv]
`default_nettype none
// Path: an accepted byte is held in the input register and parsed out of it there;
// for the final byte of a frame the result is then loaded into the output register.
// Throughput: one byte per cycle; start codes are matched on a four-byte window, one byte a step.
// A waiting result stops only a final byte; other bytes keep moving through the input register.
// Reset (rst_n low, synchronous) empties both registers, ends any partial frame, selects H.264
// and rearms the AV1 config pulse.

module annexb_config_nal_splitter import anxb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_of_frame
  input  logic        in_tlast,   // last_of_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [0] frame_sent, [1] config_found, [24:2] config_offset,
                                  // [47:25] config_length, [70:48] payload_offset,
                                  // [93:71] payload_length, [94] av1_config_pulse, [95] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // codec_mode
);

  logic       in_valid_r;
  logic [7:0] in_data_r;
  logic       in_first_r, in_last_r;
  logic       advance, load;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r, result;
  codec_t     codec_mode_r;
  logic       av1_seen_r, av1_seen_nxt;
  byte_info_t info;
  split_t     split_avc, split_hevc;

  // Input register moves on unless a final byte finds the output register still full.
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign load      = advance && in_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r  <= in_tdata;
      in_first_r <= in_tuser;
      in_last_r  <= in_tlast;
    end
  end

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= CODEC_H264;
    end else if (cfg_valid) begin
      codec_mode_r <= codec_t'(cfg_data);
    end
  end

  // Frame position and byte history.
  anxb_byte_track u_track (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .data_byte      (in_data_r),
    .first_of_frame (in_first_r),
    .last_of_frame  (in_last_r),
    .info           (info)
  );

  // Both parsers run on every frame so the mode may be chosen at its end.
  anxb_parser u_parse_avc (
    .clk   (clk),
    .rst_n (rst_n),
    .info  (info),
    .hevc  (1'b0),
    .split (split_avc)
  );

  anxb_parser u_parse_hevc (
    .clk   (clk),
    .rst_n (rst_n),
    .info  (info),
    .hevc  (1'b1),
    .split (split_hevc)
  );

  // Result for a frame ending with the byte in the input register.
  always_comb begin
    result       = '0;
    av1_seen_nxt = av1_seen_r;
    if (info.len >= MIN_LEN) begin
      result.frame_sent = 1'b1;
      result.pay_len    = info.len;
      case (codec_mode_r)
        CODEC_H264: begin
          result.cfg_found = split_avc.cfg_found;
          result.cfg_off   = split_avc.cfg_off;
          result.cfg_len   = split_avc.cfg_len;
          result.pay_off   = split_avc.pay_off;
          result.pay_len   = split_avc.pay_len;
        end
        CODEC_HEVC: begin
          result.cfg_found = split_hevc.cfg_found;
          result.cfg_off   = split_hevc.cfg_off;
          result.cfg_len   = split_hevc.cfg_len;
          result.pay_off   = split_hevc.pay_off;
          result.pay_len   = split_hevc.pay_len;
        end
        CODEC_AV1: begin
          result.av1_pulse = !av1_seen_r;
          av1_seen_nxt     = 1'b1;
        end
        default: begin
          result.pay_len = info.len;
        end
      endcase
    end
  end

  // AV1 pulse is raised once per reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av1_seen_r <= 1'b0;
    end else if (load) begin
      av1_seen_r <= av1_seen_nxt;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // A dropped frame reports nothing else.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.frame_sent |->
      (!out_r.cfg_found && !out_r.av1_pulse && (out_r.cfg_off == '0) &&
       (out_r.cfg_len == '0) && (out_r.pay_off == '0) && (out_r.pay_len == '0)))
    else $error("dropped frame carries nonzero fields");

  // The payload starts right where the config region ends.
  a_split_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.cfg_found |-> (out_r.pay_off == len_t'(out_r.cfg_off + out_r.cfg_len)))
    else $error("payload does not follow the config region");

  // A pulse is only shown once the AV1 flag has been set.
  a_pulse_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.av1_pulse |-> av1_seen_r)
    else $error("AV1 pulse without the seen flag");

  // An empty output register never holds off the input.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty output register");

endmodule

`default_nettype wire

[test/split_checker.sv]
// Watches the byte, result and codec channels, predicts the split of every frame
// and compares each result transaction with the oldest prediction.
module split_checker import anxb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_of_frame
  input  logic        in_tlast,   // last_of_frame
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,  // frame_sent, config_found, config_offset, config_length,
                                  // payload_offset, payload_length, av1_config_pulse, zero
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_data,   // codec_mode
  output int          err_count,
  output int          pending,
  output int          frames_seen,
  output int          dropped_seen,
  output int          splits_seen,
  output int          pulses_seen
);

  // Shadow of the block: bytes of the open frame, codec selection, AV1 pulse history.
  logic [7:0] frame_buf[$];
  codec_t     codec;
  logic       av1_done;
  result_t    split_q[$];

  // Bytes beyond the end of the frame read as zero.
  function automatic logic [7:0] frame_byte(input int unsigned pos);
    if (pos < frame_buf.size()) return frame_buf[pos];
    return 8'h00;
  endfunction

  // Length of the start code at pos: 3, 4, or 0 when there is none.
  function automatic int unsigned start_code_len(input int unsigned pos);
    logic [7:0] b0, b1, b2, b3;
    b0 = frame_byte(pos);
    b1 = frame_byte(pos + 1);
    b2 = frame_byte(pos + 2);
    b3 = frame_byte(pos + 3);
    if (b0 == SC_ZERO && b1 == SC_ZERO && b2 == SC_ONE) return 3;
    if (b0 == SC_ZERO && b1 == SC_ZERO && b2 == SC_ZERO && b3 == SC_ONE) return 4;
    return 0;
  endfunction

  function automatic logic [5:0] nal_at(input int unsigned pos, input logic hevc);
    logic [7:0] b;
    b = frame_byte(pos);
    if (hevc) return b[6:1];
    return {1'b0, b[4:0]};
  endfunction

  // Locates the end of the parameter sets in an H.264 or HEVC frame. The incoming
  // result already carries the whole frame as payload.
  function automatic result_t parse_parameter_sets(input result_t r, input logic hevc);
    int unsigned len, base, rem, h, sc, q, found, hdr_extra, ps_wanted;
    logic [5:0] kind, aud_kind, ps_kind;
    len       = frame_buf.size();
    base      = 0;
    rem       = len;
    found     = 0;
    aud_kind  = hevc ? NAL_AUD_HEVC : NAL_AUD_AVC;
    ps_kind   = hevc ? NAL_VPS_HEVC : NAL_SPS_AVC;
    hdr_extra = hevc ? 3 : 2;
    ps_wanted = hevc ? 3 : 2;
    sc = start_code_len(0);
    if (sc == 0) return r;
    kind = nal_at(sc, hevc);
    // A leading delimiter is skipped only when the frame goes on past it.
    if (kind == aud_kind && rem > 2 * sc + hdr_extra) begin
      base      = sc + hdr_extra;
      rem       = rem - base;
      r.pay_off = len_t'(base);
      r.pay_len = len_t'(rem);
      sc = start_code_len(base);
      if (sc == 0) return r;
      kind = nal_at(base + sc, hevc);
    end
    if (kind != ps_kind) return r;
    // The start code after the last wanted parameter set closes the config region.
    h = 0;
    while (h + 4 <= rem) begin
      q = start_code_len(base + h);
      if (q == 0) begin
        h++;
      end else if (found == ps_wanted) begin
        r.cfg_found = 1'b1;
        r.cfg_off   = len_t'(base);
        r.cfg_len   = len_t'(h);
        r.pay_off   = len_t'(base + h);
        r.pay_len   = len_t'(rem - h);
        return r;
      end else begin
        found++;
        h += q;
      end
    end
    return r;
  endfunction

  // Expected result for the frame just closed by its last byte.
  function automatic result_t predict_split();
    result_t r;
    r = '0;
    if (frame_buf.size() < MIN_FRAME_BYTES) return r;
    r.frame_sent = 1'b1;
    r.pay_len    = len_t'(frame_buf.size());
    case (codec)
      CODEC_H264: r = parse_parameter_sets(r, 1'b0);
      CODEC_HEVC: r = parse_parameter_sets(r, 1'b1);
      CODEC_AV1: begin
        if (!av1_done) begin
          av1_done    = 1'b1;
          r.av1_pulse = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Track every transaction on the three channels at the clock edge.
  always @(posedge clk) begin : watch
    result_t got, want;
    if (!rst_n) begin
      frame_buf.delete();
      split_q.delete();
      codec    = CODEC_H264;
      av1_done = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready)
        codec = codec_t'(cfg_data);

      // Compare a result transaction with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (split_q.size() == 0) begin
          err_count++;
          $display("%0t: result transaction with nothing expected, actual %h", $time, got);
        end else begin
          want = split_q.pop_front();
          check_field("frame_sent", 64'(want.frame_sent), 64'(got.frame_sent));
          check_field("config_found", 64'(want.cfg_found), 64'(got.cfg_found));
          check_field("config_offset", 64'(want.cfg_off), 64'(got.cfg_off));
          check_field("config_length", 64'(want.cfg_len), 64'(got.cfg_len));
          check_field("payload_offset", 64'(want.pay_off), 64'(got.pay_off));
          check_field("payload_length", 64'(want.pay_len), 64'(got.pay_len));
          check_field("av1_config_pulse", 64'(want.av1_pulse), 64'(got.av1_pulse));
          check_field("spare bit", 64'(want.pad), 64'(got.pad));
        end
      end

      // Collect bytes; the last byte of a frame yields one prediction.
      if (in_tvalid && in_tready) begin
        if (in_tuser)
          frame_buf.delete();
        if (frame_buf.size() < MAX_FRAME_BYTES)
          frame_buf.push_back(in_tdata);
        if (in_tlast) begin
          want = predict_split();
          split_q.push_back(want);
          frames_seen++;
          if (!want.frame_sent) dropped_seen++;
          if (want.cfg_found) splits_seen++;
          if (want.av1_pulse) pulses_seen++;
          frame_buf.delete();
        end
      end
    end
    pending <= split_q.size();
  end

endmodule

[test/tb.sv]
module tb import anxb_pkg::*; ();

  localparam int IDLE_LIMIT = 5000;
  localparam int BLOCK_BYTES = 32;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic [1:0]  cfg_data   = 2'd0;
  logic        cfg_ready;

  int err_count, pending, frames_seen, dropped_seen, splits_seen, pulses_seen;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned quiet_cycles = 0;

  // Bytes of the frame about to be sent.
  logic [7:0] frame_q[$];

  annexb_config_nal_splitter dut (.*);
  split_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random at the current rate.
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= rx_idle_pct);

  // End the run when no transaction has happened for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("[annexb_config_nal_splitter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One byte transaction, after a random gap at the current sender rate.
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stop sending, wait for every result, then let the pipeline settle.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_codec(input codec_t m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_start_code();
    if ($urandom_range(1)) frame_q.push_back(SC_ZERO);
    frame_q.push_back(SC_ZERO);
    frame_q.push_back(SC_ZERO);
    frame_q.push_back(SC_ONE);
  endtask

  // NAL header with random spare bits around the type.
  task automatic push_nal_header(input logic [5:0] kind, input logic hevc);
    logic [7:0] b;
    b = 8'($urandom);
    if (hevc) begin
      b[6:1] = kind;
      frame_q.push_back(b);
      frame_q.push_back(8'($urandom));
    end else begin
      b[4:0] = kind[4:0];
      frame_q.push_back(b);
    end
  endtask

  // NAL body, mostly free of zero bytes so start codes stay where they were put.
  task automatic push_body(input int unsigned n);
    repeat (n)
      frame_q.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(1))
                                                 : 8'($urandom_range(2, 255)));
  endtask

  // Random frame: short, noise, or a start-code structured access unit.
  task automatic build_frame(input codec_t m);
    logic        hevc;
    logic [5:0]  ps_kind;
    int unsigned pick, nals;
    frame_q.delete();
    pick    = $urandom_range(99);
    hevc    = (m == CODEC_HEVC) ^ ($urandom_range(9) == 0);
    ps_kind = hevc ? NAL_VPS_HEVC : NAL_SPS_AVC;
    if (pick < 10) begin
      // Under four bytes, so the frame is dropped.
      repeat ($urandom_range(1, 3))
        frame_q.push_back($urandom_range(1) ? SC_ZERO : 8'($urandom));
    end else if (pick < 25) begin
      // Noise rich in zero and one bytes.
      repeat ($urandom_range(4, 32)) begin
        pick = $urandom_range(9);
        frame_q.push_back(pick < 5 ? SC_ZERO : pick < 7 ? SC_ONE : 8'($urandom));
      end
    end else begin
      // Optional delimiter, sometimes a byte short or long.
      if ($urandom_range(2) == 0) begin
        push_start_code();
        push_nal_header(hevc ? NAL_AUD_HEVC : NAL_AUD_AVC, hevc);
        push_body($urandom_range(0, 2));
      end
      nals = $urandom_range(0, 5);
      for (int k = 0; k < nals; k++) begin
        push_start_code();
        push_nal_header((k == 0 && $urandom_range(4) != 0) ? ps_kind : 6'($urandom), hevc);
        push_body($urandom_range(0, 6));
      end
      // Cut the tail now and then so that reads run past the frame end.
      repeat ($urandom_range(0, 3))
        if (frame_q.size() > 1) void'(frame_q.pop_back());
      if (frame_q.size() == 0) frame_q.push_back(8'($urandom));
    end
  endtask

  // Sends frame_q. A messy frame may follow stray bytes and may lack its first mark.
  task automatic send_frame(input bit messy);
    if (messy && $urandom_range(4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'($urandom), 1'b0);
    foreach (frame_q[i])
      send_byte(frame_q[i], (i == 0) && !(messy && $urandom_range(7) == 0),
                i == frame_q.size() - 1);
  endtask

  initial begin : stimulus
    codec_t      mode;
    int unsigned bytes_goal;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: dropped frames at both byte extremes, a minimal H.264 split,
    // then the AV1 pulse on the first kept frame and not on the next.
    write_codec(CODEC_H264);
    send_byte(8'hFF, 1'b1, 1'b1);
    frame_q = '{SC_ZERO, SC_ZERO, SC_ONE};
    send_frame(1'b0);
    frame_q = '{8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h68,
                8'h00, 8'h00, 8'h01, 8'h65};
    send_frame(1'b0);
    wait_for_results();
    write_codec(CODEC_AV1);
    frame_q = '{8'h00, 8'hFF, 8'h12, 8'h0A};
    send_frame(1'b0);
    send_frame(1'b0);

    // Random frames: heavy receiver stalls, then heavy sender stalls, then neither.
    // Each block drains before its codec write.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 51 : 0;
      rx_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 15 : 0;
      for (int blk = 0; blk < 5; blk++) begin
        mode = (blk < 4) ? codec_t'((blk + phase) % 4) : codec_t'($urandom_range(1));
        wait_for_results();
        write_codec(mode);
        bytes_goal = bytes_sent + BLOCK_BYTES;
        while (bytes_sent < bytes_goal) begin
          build_frame(mode);
          send_frame(1'b1);
        end
      end
    end
    wait_for_results();

    $display("Sent %0d bytes in %0d frames: %0d dropped, %0d with a config split, %0d AV1 pulses.",
             bytes_sent, frames_seen, dropped_seen, splits_seen, pulses_seen);
    $display("All four codec modes ran under sender stalls, receiver stalls and full rate.");
    if (err_count == 0 && pending == 0)
      $display("[annexb_config_nal_splitter] OK");
    else
      $display("[annexb_config_nal_splitter] ERROR");
    $finish;
  end

endmodule

[files.f]
design/anxb_pkg.sv
design/anxb_byte_track.sv
design/anxb_parser.sv
design/annexb_config_nal_splitter.sv
test/split_checker.sv
test/tb.sv
